[sv/bba_pkg.sv]
// shared types for the bitmap block allocator
package bba_pkg;

  localparam int POS_W = 12;
  localparam int CNT_W = 13;
  localparam int BYTE_IDX_W = CNT_W - 3;
  localparam logic [CNT_W-1:0] BITS_RESET = 13'd4096;

  localparam logic OP_FIND = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] position;
    logic             bit_value;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found_position;
    logic             echoed_value;
  } rsp_t;

  typedef struct packed {
    logic       want;
    logic       first;
    logic [2:0] lo;
    logic       last;
    logic [2:0] hi;
  } scan_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } scan_res_t;

endpackage

[sv/bba_store.sv]
// byte store for the usage bitmap, one write and one registered read port
module bba_store #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bba_scan_unit.sv]
// byte match unit: first bit of a byte equal to the wanted value within limits
module bba_scan_unit
  import bba_pkg::*;
(
  input  logic [7:0] data,
  input  scan_ctl_t  ctl,
  output scan_res_t  res
);

  logic [7:0] hits;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      hits[k] = (!ctl.first || 3'(k) >= ctl.lo) &&
                (!ctl.last || 3'(k) <= ctl.hi) &&
                (data[7-k] == ctl.want);
    end
    res.hit = |hits;
    res.idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (hits[k]) begin
        res.idx = 3'(k);
      end
    end
  end

endmodule

[sv/bitmap_block_allocator.sv]
// top level of the bitmap block allocator with its scan sequencer
//
// req channel (valid/ready) carries one request: opcode find or set, a
// position and a bit value. rsp channel (valid/ready) returns one result per
// request: ok, the found or echoed position and the echoed bit value.
// cfg_we/cfg_data write bits_in_use at once; the user must write it only
// while the block is idle, which the block itself does not enforce.
// a find walks the byte store from the start byte, one byte per cycle
// through the registered read port and the byte match unit, up to the byte
// that holds the last bit in use (bits_in_use, capped at MAX_BOUND). a set is
// a read-modify-write of one byte. an out-of-range request skips the store
// and goes straight to the result state.
// one request is in flight at a time; req_ready is low while it is at work.
// a finished result waits in the output register while rsp_ready is low,
// and the next request is taken meanwhile; its result holds the sequencer
// until the register is free again.
//
// after reset the store is cleared one byte per cycle, a pass over all
// (MAX_BITS+7)/8 bytes (512 by default) during which req_ready stays low.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BITS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] MAX_BOUND = CNT_W'((MAX_BITS < 8191) ? MAX_BITS : 8191);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FETCH  = 6'b000100,
    ST_FIND   = 6'b001000,
    ST_SETW   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      bits_in_use;
  logic [AW-1:0]         clr;
  logic                  op;
  logic [POS_W-1:0]      pos;
  logic                  val;
  logic [BYTE_IDX_W-1:0] scan;
  logic [BYTE_IDX_W-1:0] data_byte;
  logic                  res_ok;
  logic [POS_W-1:0]      res_pos;

  logic [CNT_W-1:0]      bound;
  logic [CNT_W-1:0]      bound_m1;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [7:0]            wdata;
  logic [7:0]            rdata;
  logic [7:0]            byte_eff;
  logic [7:0]            mask;
  logic                  is_last;
  scan_ctl_t             sctl;
  scan_res_t             sres;

  assign bound = (bits_in_use > MAX_BOUND) ? MAX_BOUND : bits_in_use;
  assign bound_m1 = bound - CNT_W'(1);
  assign is_last = (data_byte == bound_m1[CNT_W-1:3]);
  assign byte_eff = (32'(data_byte) < DEPTH) ? rdata : 8'h00;
  assign mask = 8'h80 >> pos[2:0];
  assign req_ready = (state == ST_IDLE);

  assign sctl.want = val;
  assign sctl.first = (data_byte == {1'b0, pos[POS_W-1:3]});
  assign sctl.lo = pos[2:0];
  assign sctl.last = is_last;
  assign sctl.hi = bound_m1[2:0];

  always_comb begin
    we = 1'b0;
    waddr = AW'(data_byte);
    wdata = val ? (rdata | mask) : (rdata & ~mask);
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = 8'h00;
      end
      ST_SETW: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bba_store #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(AW'(scan)),
    .rdata(rdata)
  );

  bba_scan_unit u_scan (
    .data(byte_eff),
    .ctl(sctl),
    .res(sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BITS_RESET;
    end else if (cfg_we) begin
      bits_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != ST_RESULT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op <= req.opcode;
            pos <= req.position;
            val <= req.bit_value;
            scan <= {1'b0, req.position[POS_W-1:3]};
            if (CNT_W'(req.position) >= bound) begin
              res_ok <= 1'b0;
              res_pos <= (req.opcode == OP_SET) ? req.position : '0;
              state <= ST_RESULT;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          data_byte <= scan;
          scan <= scan + BYTE_IDX_W'(1);
          state <= (op == OP_SET) ? ST_SETW : ST_FIND;
        end
        ST_FIND: begin
          data_byte <= scan;
          scan <= scan + BYTE_IDX_W'(1);
          if (sres.hit) begin
            res_ok <= 1'b1;
            res_pos <= POS_W'({data_byte, sres.idx});
            state <= ST_RESULT;
          end else if (is_last) begin
            res_ok <= 1'b0;
            res_pos <= '0;
            state <= ST_RESULT;
          end
        end
        ST_SETW: begin
          res_ok <= 1'b1;
          res_pos <= pos;
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.ok <= res_ok;
            rsp.found_position <= res_pos;
            rsp.echoed_value <= val;
            rsp_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr <= '0;
        end
      endcase
    end
  end

endmodule

[sv/bba_checker.sv]
// port checker for the bitmap block allocator and its bind
module bba_port_checker
  import bba_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is at work");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> req_ready)
    else $error("not ready after a result was posted");

endmodule

bind bitmap_block_allocator bba_port_checker u_bba_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req(req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp(rsp)
);
